### hw/rtl/pid_position_delta_controller_assert.svh
// Assertion macros shared by the PID controller RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PID_POSITION_DELTA_CONTROLLER_ASSERT_SVH
`define PID_POSITION_DELTA_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDPD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidpd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PIDPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidpd: next-cycle check failed");

`endif

### hw/rtl/pidpd_pkg.sv
// Package for the PID controller: types, register indexes, codes and helpers.
// Used by the interfaces and by every RTL module of the block.
package pidpd_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 8;
  // Accumulator width: holds every product and sum of one step exactly.
  localparam int ACC_W = 38;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  localparam logic MODE_POSITIONAL = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE_SELECT = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_DERIV_GAIN  = 3'd3,
    REG_DRIVE_LIMIT = 3'd4,
    REG_ERROR_BOUND = 3'd5,
    REG_INTEG_LIMIT = 3'd6,
    REG_DEAD_BAND   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic        mode_select;
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [14:0] drive_limit;
    logic [15:0] error_bound;
    logic [14:0] integ_limit;
    logic [14:0] dead_band;
  } cfg_t;

  typedef struct packed {
    op_t                operation;
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;
  } item_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               error_rejected;
    logic               in_deadband;
  } result_t;

  // Clamps a value to the range -lim .. +lim.
  function automatic acc_t clamp_mag(acc_t v, acc_t lim);
    acc_t res;
    if (v > lim) begin
      res = lim;
    end else if (v < -lim) begin
      res = -lim;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### hw/rtl/pidpd_if.sv
// Valid/ready channel interfaces for the PID controller input and result items.
// Depends on pidpd_pkg.
interface pidpd_in_if;
  import pidpd_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] setpoint;
  logic signed [15:0] measured;

  modport source (output valid, output operation, output setpoint, output measured,
                  input ready);
  modport sink (input valid, input operation, input setpoint, input measured,
                output ready);
endinterface

interface pidpd_out_if;
  import pidpd_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               error_rejected;
  logic               in_deadband;

  modport source (output valid, output drive, output error_rejected, output in_deadband,
                  input ready);
  modport sink (input valid, input drive, input error_rejected, input in_deadband,
                output ready);
endinterface

### hw/rtl/pidpd_cfg_regs.sv
// Configuration register file of the PID controller.
// Decodes the plain write port into the cfg_t bundle; depends on pidpd_pkg.
module pidpd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pidpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidpd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output pidpd_pkg::cfg_t                     cfg
);
  import pidpd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MODE_SELECT: cfg_nxt.mode_select = cfg_wdata[0];
        REG_PROP_GAIN:   cfg_nxt.prop_gain   = cfg_wdata;
        REG_INTEG_GAIN:  cfg_nxt.integ_gain  = cfg_wdata;
        REG_DERIV_GAIN:  cfg_nxt.deriv_gain  = cfg_wdata;
        REG_DRIVE_LIMIT: cfg_nxt.drive_limit = cfg_wdata[14:0];
        REG_ERROR_BOUND: cfg_nxt.error_bound = cfg_wdata;
        REG_INTEG_LIMIT: cfg_nxt.integ_limit = cfg_wdata[14:0];
        REG_DEAD_BAND:   cfg_nxt.dead_band   = cfg_wdata[14:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_select <= MODE_POSITIONAL;
      cfg_r.prop_gain   <= '0;
      cfg_r.integ_gain  <= '0;
      cfg_r.deriv_gain  <= '0;
      cfg_r.drive_limit <= '1;
      cfg_r.error_bound <= '0;
      cfg_r.integ_limit <= '1;
      cfg_r.dead_band   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/pidpd_core.sv
// Combinational PID step: error and bound check, gain products, integral, clamps, deadband.
// Holds the error history and integral; depends on pidpd_pkg and the assert header.
`include "pid_position_delta_controller_assert.svh"

module pidpd_core #(
  parameter int GAIN_FRAC_BITS = pidpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pidpd_pkg::cfg_t    cfg,
  input  logic               fire,
  input  pidpd_pkg::item_t   item,
  output pidpd_pkg::result_t result
);
  import pidpd_pkg::*;

  localparam int IntegW = 16 + GAIN_FRAC_BITS;

  logic signed [16:0]       last_error_r, last_error_nxt;
  logic signed [16:0]       prior_error_r, prior_error_nxt;
  logic signed [IntegW-1:0] integ_sum_r, integ_sum_nxt;

  logic signed [16:0] err;
  logic [16:0]        mag_e;
  logic               reject;
  logic signed [17:0] de1;
  logic signed [19:0] de2;
  logic signed [19:0] p_opnd;
  logic signed [19:0] d_opnd;
  logic signed [16:0] pg_s, ig_s, dg_s;
  logic signed [36:0] p_prod;
  logic signed [33:0] i_prod;
  logic signed [36:0] d_prod;
  acc_t               ilim, dlim, dband;
  acc_t               i_term, integ_new, sum, mag;
  logic [15:0]        drv_mag;
  logic               dbz;
  logic               clr_fire;
  logic               step_fire;
  logic [IntegW+33:0] hist_vec;

  always_comb begin
    err    = 17'(item.setpoint) - 17'(item.measured);
    mag_e  = err[16] ? 17'(-err) : 17'(err);
    reject = (cfg.error_bound != '0) && (mag_e > 17'(cfg.error_bound));

    de1 = 18'(err) - 18'(last_error_r);
    de2 = 20'(err) - (20'(last_error_r) <<< 1) + 20'(prior_error_r);

    if (cfg.mode_select == MODE_POSITIONAL) begin
      p_opnd = 20'(err);
      d_opnd = 20'(de1);
    end else begin
      p_opnd = 20'(de1);
      d_opnd = de2;
    end

    pg_s   = signed'({1'b0, cfg.prop_gain});
    ig_s   = signed'({1'b0, cfg.integ_gain});
    dg_s   = signed'({1'b0, cfg.deriv_gain});
    p_prod = pg_s * p_opnd;
    i_prod = ig_s * err;
    d_prod = dg_s * d_opnd;

    ilim  = acc_t'(cfg.integ_limit) << GAIN_FRAC_BITS;
    dlim  = acc_t'(cfg.drive_limit) << GAIN_FRAC_BITS;
    dband = acc_t'(cfg.dead_band) << GAIN_FRAC_BITS;

    // Positional mode accumulates into the clamped integral; incremental mode
    // drives with the raw product and only parks a clamped copy in the state.
    if (cfg.mode_select == MODE_POSITIONAL) begin
      integ_new = clamp_mag(acc_t'(integ_sum_r) + acc_t'(i_prod), ilim);
      i_term    = integ_new;
    end else begin
      i_term    = acc_t'(i_prod);
      integ_new = clamp_mag(i_term, ilim);
    end

    sum     = clamp_mag(acc_t'(p_prod) + i_term + acc_t'(d_prod), dlim);
    mag     = sum[ACC_W-1] ? -sum : sum;
    dbz     = (cfg.dead_band != '0) && (mag < dband);
    drv_mag = 16'(mag >> GAIN_FRAC_BITS);

    result.drive          = '0;
    result.error_rejected = 1'b0;
    result.in_deadband    = 1'b0;
    last_error_nxt        = last_error_r;
    prior_error_nxt       = prior_error_r;
    integ_sum_nxt         = integ_sum_r;

    if (item.operation == OP_CLEAR) begin
      last_error_nxt  = '0;
      prior_error_nxt = '0;
      integ_sum_nxt   = '0;
    end else if (reject) begin
      result.error_rejected = 1'b1;
    end else begin
      last_error_nxt  = err;
      prior_error_nxt = last_error_r;
      integ_sum_nxt   = IntegW'(integ_new);
      if (dbz) begin
        result.in_deadband = 1'b1;
      end else begin
        result.drive = sum[ACC_W-1] ? signed'(-drv_mag) : signed'(drv_mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r  <= '0;
      prior_error_r <= '0;
      integ_sum_r   <= '0;
    end else if (fire) begin
      last_error_r  <= last_error_nxt;
      prior_error_r <= prior_error_nxt;
      integ_sum_r   <= integ_sum_nxt;
    end
  end

  assign clr_fire  = fire && (item.operation == OP_CLEAR);
  assign step_fire = fire && (item.operation == OP_STEP);
  assign hist_vec  = {last_error_r, prior_error_r, integ_sum_r};

  `PIDPD_ASSERT_NEXT(a_clear_zeroes_state, clr_fire, hist_vec == '0)
  `PIDPD_ASSERT_NEXT(a_reject_keeps_history, step_fire && reject, $stable(hist_vec))
  `PIDPD_ASSERT_NEXT(a_history_shifts, step_fire && !reject, prior_error_r == $past(last_error_r))

endmodule

### hw/rtl/pid_position_delta_controller.sv
// Top level of the PID controller: channel handshake, item and result registers.
// Depends on pidpd_pkg, the channel interfaces, pidpd_cfg_regs and pidpd_core.
`include "pid_position_delta_controller_assert.svh"

// PID controller with positional and incremental modes. Each input item either
// clears the error history and integral or computes one control step from the
// error setpoint - measured, and every item yields exactly one result item.
// The block accepts one item per clock cycle while the result side keeps up;
// an accepted item sits in the input register while the gain multipliers,
// integral update and clamps compute its result, which lands in the result
// register once that register is empty or being drained. The
// rate is set by the history loop: the last and before-last errors and the
// integral are updated in the same cycle that computes the step, so the next
// item already sees them. When the result side stalls, one more item is held
// in the input register before the input ready drops. Gains are unsigned with
// GAIN_FRAC_BITS fraction bits; the drive is the clamped sum truncated toward
// zero. Errors beyond a nonzero error bound give a zero drive with
// error_rejected set and leave the history untouched; outputs inside a nonzero
// deadband read zero with in_deadband set. Configuration registers are written
// through the cfg_ port and should only be changed while the block is idle.
module pid_position_delta_controller #(
  parameter int GAIN_FRAC_BITS = pidpd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pidpd_in_if.sink                         in_ch,
  pidpd_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [pidpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pidpd_pkg::*;

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r, s1_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t core_res;
  logic    advance;
  logic    in_fire;
  logic    core_fire;
  logic    any_flag;
  logic    both_flags;

  pidpd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidpd_core #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (core_fire),
    .item   (s1_item_r),
    .result (core_res)
  );

  // The result register can take a new value when it is empty or being drained.
  assign advance   = !out_valid_r || out_ch.ready;
  assign core_fire = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire   = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (core_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.operation <= op_t'(in_ch.operation);
      s1_item_r.setpoint  <= in_ch.setpoint;
      s1_item_r.measured  <= in_ch.measured;
    end
    if (core_fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.drive          = out_res_r.drive;
  assign out_ch.error_rejected = out_res_r.error_rejected;
  assign out_ch.in_deadband    = out_res_r.in_deadband;

  assign any_flag   = out_res_r.error_rejected || out_res_r.in_deadband;
  assign both_flags = out_res_r.error_rejected && out_res_r.in_deadband;

  `PIDPD_ASSERT_SAME(a_flags_exclusive, out_valid_r, !both_flags)
  `PIDPD_ASSERT_SAME(a_flag_zero_drive, out_valid_r && any_flag, out_res_r.drive == '0)
  `PIDPD_ASSERT_SAME(a_full_stall_blocks, s1_valid_r && !advance, !in_ch.ready)

endmodule

### dv/pid_position_delta_controller_test.sv
// Self-checking testbench for pid_position_delta_controller: a directed table, then
// random phases under several register settings, each result checked as it leaves.
// Depends on pidpd_pkg, the pidpd_in_if / pidpd_out_if channels and the block's RTL.
module pid_position_delta_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pidpd_pkg::*;

  localparam int FRAC = GAIN_FRAC_BITS_DEF;
  localparam int N_PHASES = 12;
  localparam int PHASE_ITEMS = 160;

  // A directed row is either a register write or an item. Items whose result is
  // obvious from the arithmetic carry it pinned; the rest go through the predictor.
  typedef enum logic {
    ROW_WRITE,
    ROW_ITEM
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    cfg_idx_t           idx;
    logic [15:0]        val;
    op_t                op;
    logic signed [15:0] sp;
    logic signed [15:0] ms;
    bit                 pinned;
    result_t            want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pidpd_in_if in_ch();
  pidpd_out_if out_ch();

  pid_position_delta_controller #(
    .GAIN_FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the register file and of the controller history, as the block
  // should hold them. Both limits come out of reset at their maximum.
  cfg_t               ctl_cfg = '{drive_limit: 15'h7FFF, integ_limit: 15'h7FFF,
                                  default: '0};
  logic signed [16:0] hist_last_err = '0;
  logic signed [16:0] hist_prior_err = '0;
  logic signed [23:0] integ_acc = '0;

  result_t   pending_results[$];
  int        mismatch_cnt = 0;
  bit        calm = 1'b0;
  bit        cur_pinned = 1'b0;
  result_t   cur_want = '0;
  stim_row_t plan[$];

  function automatic longint clip_mag(longint v, longint lim);
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // Computes the result of one accepted item and advances the history exactly as
  // the controller does. All products are carried in 64 bits, so nothing wraps.
  function automatic result_t pid_step(item_t it);
    result_t r;
    int      err;
    int      err_mag;
    longint  pterm;
    longint  iterm;
    longint  dterm;
    longint  total;
    longint  mag;
    longint  ilim_fx;
    r = '0;
    if (it.operation == OP_CLEAR) begin
      hist_last_err = '0;
      hist_prior_err = '0;
      integ_acc = '0;
      return r;
    end
    err = int'(it.setpoint) - int'(it.measured);
    err_mag = (err < 0) ? -err : err;
    // An out-of-bound error is reported and leaves every piece of state alone.
    if (ctl_cfg.error_bound != 0 && err_mag > int'(ctl_cfg.error_bound)) begin
      r.error_rejected = 1'b1;
      return r;
    end
    ilim_fx = longint'(ctl_cfg.integ_limit) << FRAC;
    if (ctl_cfg.mode_select == MODE_POSITIONAL) begin
      pterm = longint'(ctl_cfg.prop_gain) * err;
      integ_acc = clip_mag(integ_acc + longint'(ctl_cfg.integ_gain) * err, ilim_fx);
      iterm = integ_acc;
      dterm = longint'(ctl_cfg.deriv_gain) * (err - hist_last_err);
    end else begin
      // Incremental mode uses the raw integral product in the sum but still
      // stores a clamped copy, which positional mode picks up after a switch.
      pterm = longint'(ctl_cfg.prop_gain) * (err - hist_last_err);
      iterm = longint'(ctl_cfg.integ_gain) * err;
      integ_acc = clip_mag(iterm, ilim_fx);
      dterm = longint'(ctl_cfg.deriv_gain) * (err - 2 * hist_last_err + hist_prior_err);
    end
    total = clip_mag(pterm + iterm + dterm, longint'(ctl_cfg.drive_limit) << FRAC);
    hist_prior_err = hist_last_err;
    hist_last_err = err;
    mag = (total < 0) ? -total : total;
    if (ctl_cfg.dead_band != 0 && mag < (longint'(ctl_cfg.dead_band) << FRAC)) begin
      r.in_deadband = 1'b1;
    end else begin
      mag = mag >>> FRAC;
      r.drive = (total < 0) ? -mag : mag;
    end
    return r;
  endfunction

  function automatic stim_row_t row_write(cfg_idx_t idx, logic [15:0] val);
    stim_row_t row;
    row = '{kind: ROW_WRITE, idx: idx, val: val, op: OP_STEP, sp: '0, ms: '0,
            pinned: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t row_item(op_t op, int sp, int ms, bit pinned,
                                         int drv, bit rej, bit db);
    stim_row_t row;
    row = '{kind: ROW_ITEM, idx: REG_MODE_SELECT, val: '0, op: op, sp: 16'(sp),
            ms: 16'(ms), pinned: pinned, want: '{16'(drv), rej, db}};
    return row;
  endfunction

  // Puts one write on the port and waits for the edge that takes it. The write enable is left high so
  // that back-to-back writes never lower and raise it within one step.
  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MODE_SELECT: ctl_cfg.mode_select = val[0];
      REG_PROP_GAIN:   ctl_cfg.prop_gain = val;
      REG_INTEG_GAIN:  ctl_cfg.integ_gain = val;
      REG_DERIV_GAIN:  ctl_cfg.deriv_gain = val;
      REG_DRIVE_LIMIT: ctl_cfg.drive_limit = val[14:0];
      REG_ERROR_BOUND: ctl_cfg.error_bound = val;
      REG_INTEG_LIMIT: ctl_cfg.integ_limit = val[14:0];
      REG_DEAD_BAND:   ctl_cfg.dead_band = val[14:0];
      default: ;
    endcase
  endtask

  task automatic write_cfg(cfg_t c);
    write_reg(REG_MODE_SELECT, {15'b0, c.mode_select});
    write_reg(REG_PROP_GAIN, c.prop_gain);
    write_reg(REG_INTEG_GAIN, c.integ_gain);
    write_reg(REG_DERIV_GAIN, c.deriv_gain);
    write_reg(REG_DRIVE_LIMIT, {1'b0, c.drive_limit});
    write_reg(REG_ERROR_BOUND, c.error_bound);
    write_reg(REG_INTEG_LIMIT, {1'b0, c.integ_limit});
    write_reg(REG_DEAD_BAND, {1'b0, c.dead_band});
    cfg_we <= 1'b0;
  endtask

  // Stops offering items and waits until every outstanding result is back and
  // the two-stage pipeline is empty, so registers can change safely.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Offers one item after an optional idle gap and returns at the edge that
  // accepts it. Valid stays high so the next item can follow without a bubble.
  task automatic send_item(item_t it, bit pinned, result_t want, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= it.operation;
    in_ch.setpoint <= it.setpoint;
    in_ch.measured <= it.measured;
    cur_pinned <= pinned;
    cur_want <= want;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic note_mismatch(string what, result_t want, result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch (%s): expected drive %0d rej %0b db %0b, got drive %0d rej %0b db %0b",
               what, want.drive, want.error_rejected, want.in_deadband,
               got.drive, got.error_rejected, got.in_deadband);
    end
  endtask

  // Result side: ready drops in bursts between high runs, both of random length,
  // and stays high throughout the calm closing phase.
  int ready_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ch.ready <= 1'b1;
    end else if (ready_cnt > 0) begin
      ready_cnt <= ready_cnt - 1;
    end else if (out_ch.ready) begin
      out_ch.ready <= 1'b0;
      ready_cnt <= $urandom_range(0, 16);
    end else begin
      out_ch.ready <= 1'b1;
      ready_cnt <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
    end
  end

  // Both handshakes are sampled at the same edge. An accepted item is predicted
  // before any result of the same edge is checked, so process order cannot matter.
  always @(posedge clk) begin : monitor_blk
    item_t   seen;
    result_t want;
    result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.operation = op_t'(in_ch.operation);
        seen.setpoint = in_ch.setpoint;
        seen.measured = in_ch.measured;
        want = pid_step(seen);
        // A pinned row checks the block against the hand-worked value instead.
        if (cur_pinned) begin
          want = cur_want;
        end
        pending_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.drive = out_ch.drive;
        got.error_rejected = out_ch.error_rejected;
        got.in_deadband = out_ch.in_deadband;
        if (pending_results.size() == 0) begin
          note_mismatch("result with no item pending", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.drive !== want.drive) begin
            note_mismatch("drive", want, got);
          end else if (got.error_rejected !== want.error_rejected) begin
            note_mismatch("error_rejected", want, got);
          end else if (got.in_deadband !== want.in_deadband) begin
            note_mismatch("in_deadband", want, got);
          end
        end
      end
    end
  end

  initial begin : stimulus
    item_t it;
    cfg_t  c;
    int    gap;
    int    gap_odds;
    int    delta;

    in_ch.valid = 1'b0;
    in_ch.operation = OP_STEP;
    in_ch.setpoint = '0;
    in_ch.measured = '0;

    // Directed part. After reset every gain is zero, so any step drives zero.
    plan.push_back(row_item(OP_STEP, 32767, -32768, 1, 0, 0, 0));
    plan.push_back(row_item(OP_CLEAR, 0, 0, 1, 0, 0, 0));
    // Unity proportional gain: the drive is the error itself, up to the limit.
    plan.push_back(row_write(REG_PROP_GAIN, 16'h0100));
    plan.push_back(row_item(OP_STEP, 100, 0, 1, 100, 0, 0));
    plan.push_back(row_item(OP_STEP, -32768, 32767, 1, -32767, 0, 0));
    plan.push_back(row_item(OP_STEP, 32767, -32768, 1, 32767, 0, 0));
    // Error bound: beyond it the result is rejected, at it the step goes through.
    plan.push_back(row_write(REG_ERROR_BOUND, 16'd1000));
    plan.push_back(row_item(OP_STEP, 2000, 0, 1, 0, 1, 0));
    plan.push_back(row_item(OP_STEP, -1000, 1, 1, 0, 1, 0));
    plan.push_back(row_item(OP_STEP, 1000, 0, 1, 1000, 0, 0));
    // Deadband: magnitudes just below it read zero, the edge itself passes.
    plan.push_back(row_write(REG_DEAD_BAND, 16'd50));
    plan.push_back(row_item(OP_STEP, 49, 0, 1, 0, 0, 1));
    plan.push_back(row_item(OP_STEP, -50, 0, 1, -50, 0, 0));
    plan.push_back(row_item(OP_STEP, 0, 49, 1, 0, 0, 1));
    // Integral and derivative terms with a tight integral clamp.
    plan.push_back(row_write(REG_INTEG_GAIN, 16'h0080));
    plan.push_back(row_write(REG_DERIV_GAIN, 16'h0040));
    plan.push_back(row_write(REG_INTEG_LIMIT, 16'd100));
    plan.push_back(row_item(OP_STEP, 300, 0, 0, 0, 0, 0));
    plan.push_back(row_item(OP_STEP, 300, 100, 0, 0, 0, 0));
    plan.push_back(row_item(OP_STEP, -200, 100, 0, 0, 0, 0));
    plan.push_back(row_item(OP_STEP, 0, 0, 0, 0, 0, 0));
    plan.push_back(row_item(OP_CLEAR, 1234, -77, 1, 0, 0, 0));
    // Incremental mode, including a rejected step that must not touch history.
    plan.push_back(row_write(REG_MODE_SELECT, {15'b0, MODE_INCREMENTAL}));
    plan.push_back(row_item(OP_STEP, 500, 0, 0, 0, 0, 0));
    plan.push_back(row_item(OP_STEP, 520, 0, 0, 0, 0, 0));
    plan.push_back(row_item(OP_STEP, -600, -32768, 1, 0, 1, 0));
    plan.push_back(row_item(OP_STEP, 400, 100, 0, 0, 0, 0));
    // A zero drive limit forces every drive to zero.
    plan.push_back(row_write(REG_ERROR_BOUND, 16'd0));
    plan.push_back(row_write(REG_DRIVE_LIMIT, 16'd0));
    plan.push_back(row_write(REG_DEAD_BAND, 16'd0));
    plan.push_back(row_item(OP_STEP, 32767, -32768, 1, 0, 0, 0));
    // Every gain at its maximum in positional mode: the sum saturates.
    plan.push_back(row_write(REG_MODE_SELECT, {15'b0, MODE_POSITIONAL}));
    plan.push_back(row_write(REG_DRIVE_LIMIT, 16'h7FFF));
    plan.push_back(row_write(REG_INTEG_LIMIT, 16'h7FFF));
    plan.push_back(row_write(REG_PROP_GAIN, 16'hFFFF));
    plan.push_back(row_write(REG_INTEG_GAIN, 16'hFFFF));
    plan.push_back(row_write(REG_DERIV_GAIN, 16'hFFFF));
    plan.push_back(row_item(OP_STEP, -32768, 32767, 1, -32767, 0, 0));
    plan.push_back(row_item(OP_STEP, 32767, -32768, 0, 0, 0, 0));
    plan.push_back(row_item(OP_CLEAR, -1, -1, 1, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_WRITE) begin
        // A batch of writes starts only once the block has gone quiet, and the
        // enable drops after its last write.
        if (n == 0 || plan[n-1].kind != ROW_WRITE) begin
          drain();
        end
        write_reg(plan[n].idx, plan[n].val);
        if (n == plan.size() - 1 || plan[n+1].kind != ROW_WRITE) begin
          cfg_we <= 1'b0;
        end
      end else begin
        it.operation = plan[n].op;
        it.setpoint = plan[n].sp;
        it.measured = plan[n].ms;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 17) : 0;
        send_item(it, plan[n].pinned, plan[n].want, gap);
      end
    end

    // Random phases. The first three pin register extremes; the rest draw mixed
    // settings that lean toward small gains so that drives stay off the clamps.
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      c.mode_select = $urandom_range(0, 1);
      case ($urandom_range(0, 7))
        0: c.prop_gain = '0;
        1: c.prop_gain = 16'hFFFF;
        6, 7: c.prop_gain = $urandom;
        default: c.prop_gain = $urandom_range(0, 16'h0200);
      endcase
      case ($urandom_range(0, 7))
        0: c.integ_gain = '0;
        1: c.integ_gain = 16'hFFFF;
        6, 7: c.integ_gain = $urandom;
        default: c.integ_gain = $urandom_range(0, 16'h0100);
      endcase
      case ($urandom_range(0, 7))
        0: c.deriv_gain = '0;
        1: c.deriv_gain = 16'hFFFF;
        6, 7: c.deriv_gain = $urandom;
        default: c.deriv_gain = $urandom_range(0, 16'h0100);
      endcase
      case ($urandom_range(0, 7))
        0: c.drive_limit = '0;
        1, 2: c.drive_limit = 15'h7FFF;
        default: c.drive_limit = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(0, 7))
        0: c.integ_limit = '0;
        1, 2: c.integ_limit = 15'h7FFF;
        3, 4: c.integ_limit = $urandom_range(1, 500);
        default: c.integ_limit = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(0, 3))
        0: c.error_bound = '0;
        1: c.error_bound = 16'hFFFF;
        2: c.error_bound = $urandom_range(1, 2000);
        default: c.error_bound = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0, 1: c.dead_band = '0;
        2: c.dead_band = $urandom_range(1, 200);
        default: c.dead_band = $urandom_range(0, 32767);
      endcase
      if (p == 0 || p == 1) begin
        c.mode_select = (p == 0) ? MODE_POSITIONAL : MODE_INCREMENTAL;
        c.prop_gain = 16'hFFFF;
        c.integ_gain = 16'hFFFF;
        c.deriv_gain = 16'hFFFF;
        c.drive_limit = 15'h7FFF;
        c.integ_limit = 15'h7FFF;
        c.error_bound = '0;
        c.dead_band = '0;
      end else if (p == 2) begin
        c.drive_limit = '0;
        c.integ_limit = '0;
        c.error_bound = 16'hFFFF;
        c.dead_band = 15'h7FFF;
      end
      write_cfg(c);
      // The closing phase runs with no idling on either side.
      calm <= (p == N_PHASES - 1);
      gap_odds = $urandom_range(1, 8);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        it.operation = ($urandom_range(0, 29) == 0) ? OP_CLEAR : OP_STEP;
        it.setpoint = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          it.measured = $urandom;
        end else begin
          // Measurement close to the setpoint keeps the error in the useful
          // range; the sum may wrap at the ends of the field, which is fine.
          delta = int'($urandom_range(0, 600)) - 300;
          it.measured = 16'(int'(it.setpoint) + delta);
        end
        gap = (p != N_PHASES - 1 && $urandom_range(0, gap_odds) == 0) ?
              $urandom_range(1, 17) : 0;
        send_item(it, 1'b0, '0, gap);
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("pid_position_delta_controller_test OK");
    end else begin
      $display("pid_position_delta_controller_test NOT OK");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run with every gap and stall.
  initial begin
    #5_000_000;
    $display("pid_position_delta_controller_test NOT OK");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pidpd_pkg.sv
hw/rtl/pidpd_if.sv
hw/rtl/pidpd_cfg_regs.sv
hw/rtl/pidpd_core.sv
hw/rtl/pid_position_delta_controller.sv
dv/pid_position_delta_controller_test.sv
